>>> hw/rtl/hst_pkg.sv
// ----------------------------------------------------------------------------
// hst_pkg
// Shared types, constants and SHA-256 helper functions for the HMAC
// transport code block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hst_pkg;

  localparam int unsigned MAX_MESSAGE_BYTES_DEF = 256;
  localparam int unsigned COUNT_W = 10;
  localparam logic [15:0] CODE_RESERVED = 16'hFFFF;

  typedef logic [0:7][31:0] hash_t;
  typedef logic [0:15][31:0] block_t;

  typedef enum logic {
    REG_KEY_LOW  = 1'b0,
    REG_KEY_HIGH = 1'b1
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BYTE,
    ST_FIN,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_POST,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    JOB_IPAD,
    JOB_DATA,
    JOB_PAD1,
    JOB_INNER,
    JOB_OPAD,
    JOB_OUTER
  } job_t;

  localparam hash_t H_INIT = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [0:63][31:0] ROUND_K = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  // Key bytes 0..15 in big-endian word order, zero padded, XOR the pad byte.
  function automatic block_t key_block(input logic [63:0] lo, input logic [63:0] hi,
                                       input logic [7:0] pad);
    block_t b;
    logic [127:0] k;
    k = {hi, lo};
    for (int i = 0; i < 16; i++) begin
      b[i] = {4{pad}};
    end
    for (int i = 0; i < 16; i++) begin
      b[i >> 2][(3 - (i & 3)) * 8 +: 8] = k[i * 8 +: 8] ^ pad;
    end
    return b;
  endfunction

endpackage

>>> hw/rtl/hmac_sha256_transport_code.sv
// ----------------------------------------------------------------------------
// hmac_sha256_transport_code
// Byte-serial HMAC-SHA256 over a message with a 128-bit key, one shared
// SHA-256 round unit doing one round per cycle.
// A byte that closes a 64-byte block or starts a message also runs one
// block compression. The last byte runs 3 or 4 more, or none after a
// length error, then waits for any previous result to be taken.
// Reset clears the sequencer, byte count, overflow flag, keys and result_valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hmac_sha256_transport_code #(
  parameter int unsigned MAX_MESSAGE_BYTES = hst_pkg::MAX_MESSAGE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        message_valid,
  output logic        message_ready,
  input  logic [7:0]  message_byte,
  input  logic        last_byte,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [15:0] transport_code,
  output logic        length_error
);
  import hst_pkg::*;

  localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_MESSAGE_BYTES);

  state_t state, state_next;
  job_t job;
  logic [63:0] key_low, key_high;
  logic [COUNT_W-1:0] byte_count;
  logic overflow_flag;
  logic [7:0] byte_r;
  logic last_r;
  logic [5:0] rnd;
  hash_t hash_words, inner_digest, work;
  block_t block_words, opad_block;
  logic [31:0] t1, t2, w_new, len_bits;
  logic [15:0] code_raw, code_fixed;
  logic at_limit, out_free, out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low <= '0;
      key_high <= '0;
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_KEY_LOW: key_low <= cfg_data;
        REG_KEY_HIGH: key_high <= cfg_data;
        default: ;
      endcase
    end
  end

  assign at_limit = byte_count >= MAX_COUNT;
  assign out_free = !result_valid || result_ready;
  assign len_bits = {18'd0, 11'({1'b0, byte_count} + 11'd64), 3'd0};

  assign t1 = work[7] + bsig1(work[4]) + ((work[4] & work[5]) ^ (~work[4] & work[6]))
            + ROUND_K[rnd] + block_words[0];
  assign t2 = bsig0(work[0]) + ((work[0] & work[1]) ^ (work[0] & work[2])
            ^ (work[1] & work[2]));
  assign w_new = block_words[0] + ssig0(block_words[1]) + block_words[9]
               + ssig1(block_words[14]);

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      opad_block[i] = inner_digest[i];
    end
    opad_block[8] = 32'h8000_0000;
    for (int i = 9; i < 15; i++) begin
      opad_block[i] = 32'd0;
    end
    opad_block[15] = 32'd768;
  end

  assign code_raw = {hash_words[0][23:16], hash_words[0][31:24]};
  always_comb begin
    priority if (code_raw == 16'd0) begin
      code_fixed = 16'd1;
    end else if (code_raw == CODE_RESERVED) begin
      code_fixed = CODE_RESERVED - 16'd1;
    end else begin
      code_fixed = code_raw;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (message_valid) begin
          state_next = (byte_count == '0 && !overflow_flag) ? ST_LOAD : ST_BYTE;
        end
      end
      ST_BYTE: begin
        if (!at_limit && !overflow_flag && byte_count[5:0] == 6'd63) begin
          state_next = ST_LOAD;
        end else begin
          state_next = last_r ? ST_FIN : ST_IDLE;
        end
      end
      ST_FIN: state_next = overflow_flag ? ST_OUT : ST_LOAD;
      ST_LOAD: state_next = ST_ROUND;
      ST_ROUND: state_next = (rnd == 6'd63) ? ST_ADD : ST_ROUND;
      ST_ADD: state_next = ST_POST;
      ST_POST: begin
        unique case (job)
          JOB_IPAD: state_next = ST_BYTE;
          JOB_DATA: state_next = last_r ? ST_FIN : ST_IDLE;
          JOB_OUTER: state_next = ST_OUT;
          default: state_next = ST_LOAD;
        endcase
      end
      ST_OUT: state_next = out_free ? ST_IDLE : ST_OUT;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    message_ready = (state == ST_IDLE);
    out_load = (state == ST_OUT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      byte_count <= '0;
      overflow_flag <= 1'b0;
      result_valid <= 1'b0;
      rnd <= '0;
      job <= JOB_IPAD;
    end else begin
      state <= state_next;
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (message_valid) begin
            job <= JOB_IPAD;
          end
        end
        ST_BYTE: begin
          if (at_limit) begin
            overflow_flag <= 1'b1;
          end else if (!overflow_flag) begin
            byte_count <= byte_count + 1'b1;
            job <= JOB_DATA;
          end
        end
        ST_FIN: begin
          job <= (byte_count[5:0] > 6'd55) ? JOB_PAD1 : JOB_INNER;
        end
        ST_LOAD: rnd <= '0;
        ST_ROUND: rnd <= rnd + 1'b1;
        ST_POST: begin
          unique case (job)
            JOB_PAD1: job <= JOB_INNER;
            JOB_INNER: job <= JOB_OPAD;
            JOB_OPAD: job <= JOB_OUTER;
            default: ;
          endcase
        end
        ST_OUT: begin
          if (out_load) begin
            result_valid <= 1'b1;
            byte_count <= '0;
            overflow_flag <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (message_valid) begin
          byte_r <= message_byte;
          last_r <= last_byte;
          if (byte_count == '0 && !overflow_flag) begin
            hash_words <= H_INIT;
            block_words <= key_block(key_low, key_high, 8'h36);
          end
        end
      end
      ST_BYTE: begin
        if (!at_limit && !overflow_flag) begin
          block_words[byte_count[5:2]][{~byte_count[1:0], 3'b000} +: 8] <= byte_r;
        end
      end
      ST_FIN: begin
        if (!overflow_flag) begin
          block_words[byte_count[5:2]][{~byte_count[1:0], 3'b000} +: 8] <= 8'h80;
          if (byte_count[5:0] <= 6'd55) begin
            block_words[15] <= len_bits;
          end
        end
      end
      ST_LOAD: work <= hash_words;
      ST_ROUND: begin
        work <= {t1 + t2, work[0], work[1], work[2], work[3] + t1,
                 work[4], work[5], work[6]};
        for (int i = 0; i < 15; i++) begin
          block_words[i] <= block_words[i + 1];
        end
        block_words[15] <= w_new;
      end
      ST_ADD: begin
        for (int i = 0; i < 8; i++) begin
          hash_words[i] <= hash_words[i] + work[i];
        end
      end
      ST_POST: begin
        unique case (job)
          JOB_IPAD, JOB_DATA: block_words <= '0;
          JOB_PAD1: begin
            block_words <= '0;
            block_words[15] <= len_bits;
          end
          JOB_INNER: begin
            inner_digest <= hash_words;
            hash_words <= H_INIT;
            block_words <= key_block(key_low, key_high, 8'h5C);
          end
          JOB_OPAD: block_words <= opad_block;
          default: ;
        endcase
      end
      ST_OUT: begin
        if (out_load) begin
          transport_code <= overflow_flag ? 16'd0 : code_fixed;
          length_error <= overflow_flag;
        end
      end
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    result_valid && length_error |-> transport_code == 16'd0)
    else $error("Length error result carries a nonzero code.");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && !length_error |-> transport_code != 16'd0 &&
      transport_code != CODE_RESERVED)
    else $error("Reserved transport code delivered.");

  assert property (@(posedge clk) disable iff (rst)
    byte_count <= MAX_COUNT)
    else $error("Byte count ran past the message bound.");

  assert property (@(posedge clk) disable iff (rst)
    state == ST_ROUND && rnd == 6'd63 |=> state == ST_ADD && rnd == 6'd0)
    else $error("Compression did not end after the last round.");

endmodule
